// File: sv/cocnt_pkg.sv
// ----------------------------------------------------------------------------
// cocnt_pkg
// Shared types and constants for the code occurrence counter table.
// ----------------------------------------------------------------------------
package cocnt_pkg;

   localparam int unsigned REQ_CODE_BITS = 16;
   localparam int unsigned RSP_COUNT_BITS = 16;

   typedef struct packed {
      logic act;
      logic done;
      logic is_new;
   } tok_ctl_type;

endpackage

// File: sv/code_occurrence_counter_table.sv
// ----------------------------------------------------------------------------
// code_occurrence_counter_table
// Counts occurrences of event codes in a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one event code per transaction; rsp_ returns one
//   transaction per request with the updated count and the new-entry and
//   flush flags. A transaction moves when valid is high and stall is low.
//   Each lookup walks the chain of TABLE_ENTRIES cells, one cell a cycle;
//   the cell holding the code counts it, or the first free cell takes it.
//   A miss on a full table restarts it: the code goes into entry zero alone.
//   One lookup is in flight at a time, so a request is not taken until the
//   lookup before it has finished.
//   A finished result waits in a holding register, so the next request can
//   be taken while the response is stalled; req_stall stays high from
//   acceptance until the result moves into the response register.
//   Reset empties the table (fill level zero) and drops all valids.
// ----------------------------------------------------------------------------
module code_occurrence_counter_table
   import cocnt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 64,
   parameter int unsigned CODE_BITS     = 16,
   parameter int unsigned COUNT_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [REQ_CODE_BITS-1:0]  req_event_code,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RSP_COUNT_BITS-1:0] rsp_occurrences,
   output logic                      rsp_new_entry,
   output logic                      rsp_table_flushed
);

   localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned CW = (CODE_BITS > REQ_CODE_BITS) ? CODE_BITS : REQ_CODE_BITS;
   localparam int unsigned OW = (COUNT_BITS > RSP_COUNT_BITS) ? COUNT_BITS : RSP_COUNT_BITS;
   localparam logic [FILL_W-1:0]     FILL_ONE  = FILL_W'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   tok_ctl_type           tok   [0:TABLE_ENTRIES];
   logic [CODE_BITS-1:0]  code_c[0:TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] cnt_c [0:TABLE_ENTRIES];

   logic [CW-1:0]         code_wide;
   logic [OW-1:0]         count_wide;
   logic                  req_accept, end_act, flush, rsp_free;

   logic                  busy_ff, busy_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [COUNT_BITS-1:0] pend_count_ff, pend_count_in;
   logic                  pend_new_ff, pend_new_in;
   logic                  pend_flush_ff, pend_flush_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_new_ff, rsp_new_in;
   logic                  rsp_flush_ff, rsp_flush_in;

   assign req_accept = req_valid & ~busy_ff;
   assign code_wide  = CW'(req_event_code);

   assign tok[0].act    = req_accept;
   assign tok[0].done   = 1'b0;
   assign tok[0].is_new = 1'b0;
   assign code_c[0]     = code_wide[CODE_BITS-1:0];
   assign cnt_c[0]      = COUNT_ONE;

   assign end_act = tok[TABLE_ENTRIES].act;
   assign flush   = end_act & ~tok[TABLE_ENTRIES].done;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
         cocnt_cell #(
            .CODE_BITS  (CODE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .FILL_W     (FILL_W),
            .INDEX      (gi)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .fill_level (fill_ff),
            .tok_in     (tok[gi]),
            .code_in    (code_c[gi]),
            .count_in   (cnt_c[gi]),
            .load       ((gi == 0) ? flush : 1'b0),
            .load_code  (code_c[TABLE_ENTRIES]),
            .tok_out    (tok[gi+1]),
            .code_out   (code_c[gi+1]),
            .count_out  (cnt_c[gi+1])
         );
      end
   endgenerate

   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign count_wide = OW'(pend_count_ff);

   always_comb begin
      busy_in       = busy_ff | req_accept;
      fill_in       = fill_ff;
      pend_valid_in = pend_valid_ff;
      pend_count_in = pend_count_ff;
      pend_new_in   = pend_new_ff;
      pend_flush_in = pend_flush_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_flush_in  = rsp_flush_ff;

      if (end_act) begin
         pend_valid_in = 1'b1;
         if (flush) begin
            fill_in       = FILL_ONE;
            pend_count_in = COUNT_ONE;
            pend_new_in   = 1'b1;
            pend_flush_in = 1'b1;
         end else begin
            if (tok[TABLE_ENTRIES].is_new) begin
               fill_in = fill_ff + FILL_ONE;
            end
            pend_count_in = cnt_c[TABLE_ENTRIES];
            pend_new_in   = tok[TABLE_ENTRIES].is_new;
            pend_flush_in = 1'b0;
         end
      end

      if (rsp_free) begin
         rsp_valid_in = pend_valid_ff;
         if (pend_valid_ff) begin
            rsp_count_in  = count_wide[RSP_COUNT_BITS-1:0];
            rsp_new_in    = pend_new_ff;
            rsp_flush_in  = pend_flush_ff;
            pend_valid_in = 1'b0;
            busy_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_count_ff <= pend_count_in;
      pend_new_ff   <= pend_new_in;
      pend_flush_ff <= pend_flush_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_flush_ff  <= rsp_flush_in;
      if (reset) begin
         busy_ff       <= 1'b0;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_stall         = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_occurrences   = rsp_count_ff;
   assign rsp_new_entry     = rsp_new_ff;
   assign rsp_table_flushed = rsp_flush_ff;

endmodule

// File: sv/cocnt_cell.sv
// ----------------------------------------------------------------------------
// cocnt_cell
// One table entry: compares the passing lookup against its code, counts
// a hit or takes the code on a miss at the fill slot (or on a load), then hands on.
// ----------------------------------------------------------------------------
module cocnt_cell
   import cocnt_pkg::*;
#(
   parameter int unsigned CODE_BITS  = 16,
   parameter int unsigned COUNT_BITS = 16,
   parameter int unsigned FILL_W     = 7,
   parameter int unsigned INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [FILL_W-1:0]     fill_level,
   input  tok_ctl_type           tok_in,
   input  logic [CODE_BITS-1:0]  code_in,
   input  logic [COUNT_BITS-1:0] count_in,
   input  logic                  load,
   input  logic [CODE_BITS-1:0]  load_code,
   output tok_ctl_type           tok_out,
   output logic [CODE_BITS-1:0]  code_out,
   output logic [COUNT_BITS-1:0] count_out
);

   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [CODE_BITS-1:0]  entry_code_ff, entry_code_in;
   logic [COUNT_BITS-1:0] entry_count_ff, entry_count_in;
   tok_ctl_type           tok_ff, tok_fwd_in;
   logic [CODE_BITS-1:0]  code_ff;
   logic [COUNT_BITS-1:0] count_ff, count_fwd_in;
   logic                  valid, slot, match, ins;
   logic [COUNT_BITS-1:0] count_inc;

   assign valid = fill_level > FILL_W'(INDEX);
   assign slot  = fill_level == FILL_W'(INDEX);
   assign match = tok_in.act & ~tok_in.done & valid & (entry_code_ff == code_in);
   assign ins   = tok_in.act & ~tok_in.done & slot;
   assign count_inc = (entry_count_ff == COUNT_MAX) ? entry_count_ff
                                                    : entry_count_ff + COUNT_ONE;

   always_comb begin
      entry_code_in  = entry_code_ff;
      entry_count_in = entry_count_ff;
      priority if (load) begin
         entry_code_in  = load_code;
         entry_count_in = COUNT_ONE;
      end else if (ins) begin
         entry_code_in  = code_in;
         entry_count_in = COUNT_ONE;
      end else if (match) begin
         entry_count_in = count_inc;
      end
   end

   always_comb begin
      tok_fwd_in.act    = tok_in.act;
      tok_fwd_in.done   = tok_in.done | match | ins;
      tok_fwd_in.is_new = tok_in.is_new | ins;
      priority if (match) begin
         count_fwd_in = count_inc;
      end else if (ins) begin
         count_fwd_in = COUNT_ONE;
      end else begin
         count_fwd_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_code_ff  <= entry_code_in;
      entry_count_ff <= entry_count_in;
      code_ff        <= code_in;
      count_ff       <= count_fwd_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_fwd_in;
      end
   end

   assign tok_out   = tok_ff;
   assign code_out  = code_ff;
   assign count_out = count_ff;

endmodule

// File: sv/cocnt_chk.sv
// ----------------------------------------------------------------------------
// cocnt_chk
// Port-level checks for the code occurrence counter table.
// ----------------------------------------------------------------------------
module cocnt_chk
   import cocnt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [RSP_COUNT_BITS-1:0] rsp_occurrences,
   input logic                      rsp_new_entry,
   input logic                      rsp_table_flushed
);

   // one lookup in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a lookup is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response transaction dropped");

   a_flush_is_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_flushed) |-> rsp_new_entry)
      else $error("flush reported without a new entry");

   a_new_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_entry) |-> (rsp_occurrences == RSP_COUNT_BITS'(1)))
      else $error("new entry with count other than one");

endmodule

bind code_occurrence_counter_table cocnt_chk u_cocnt_chk (.*);

// File: tb/sv/tb_code_occurrence_counter_table.sv
// ----------------------------------------------------------------------------
// tb_code_occurrence_counter_table
// Self-checking bench for the code occurrence counter table. A directed table
// of codes is followed by random bursts: hot sets that build up high counts,
// sweeps wide enough to fill and flush the table, and noise.
// Every result is checked against an in-bench count table or a directed row,
// with random idling on both channels and long response hold-offs.
// ----------------------------------------------------------------------------
module tb_code_occurrence_counter_table;
   import cocnt_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int DUT_ENTRIES    = 64;
   localparam int DUT_CODE_BITS  = 16;
   localparam int DUT_COUNT_BITS = 16;
   localparam logic [DUT_COUNT_BITS-1:0] COUNT_MAX = {DUT_COUNT_BITS{1'b1}};
   localparam int RANDOM_ITEMS   = 600;
   localparam int LONG_HOLD      = 500;
   localparam int CYCLE_LIMIT    = 1500000;
   localparam int DIR_ROWS       = 18;

   typedef struct packed {
      logic [RSP_COUNT_BITS-1:0] occurrences;
      logic                      new_entry;
      logic                      table_flushed;
   } count_result_type;

   typedef struct packed {
      logic [REQ_CODE_BITS-1:0]  code;
      logic                      fixed;
      logic [RSP_COUNT_BITS-1:0] occurrences;
      logic                      new_entry;
      logic                      table_flushed;
   } code_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [REQ_CODE_BITS-1:0]  req_event_code;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [RSP_COUNT_BITS-1:0] rsp_occurrences;
   logic                      rsp_new_entry;
   logic                      rsp_table_flushed;

   // in-bench copy of the count table
   logic [DUT_CODE_BITS-1:0]  tbl_codes  [DUT_ENTRIES];
   logic [DUT_COUNT_BITS-1:0] tbl_counts [DUT_ENTRIES];
   int                        tbl_fill = 0;

   count_result_type awaited_counts [$];
   int  errors       = 0;
   int  rsp_seen     = 0;
   int  n_inserts    = 0;
   int  n_flushes    = 0;
   int  n_saturated  = 0;
   int  n_backpress  = 0;
   int  cycles       = 0;
   logic quiet       = 1'b0;

   code_row_type code_rows [DIR_ROWS] = '{
      '{16'h0000, 1'b1, 16'd1, 1'b1, 1'b0},
      '{16'h0000, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'hFFFF, 1'b1, 16'd1, 1'b1, 1'b0},
      '{16'hFFFF, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'h0000, 1'b1, 16'd3, 1'b0, 1'b0},
      '{16'h8000, 1'b1, 16'd1, 1'b1, 1'b0},
      '{16'h7FFF, 1'b1, 16'd1, 1'b1, 1'b0},
      '{16'h0001, 1'b1, 16'd1, 1'b1, 1'b0},
      '{16'h8000, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'h5555, 1'b0, 16'd0, 1'b0, 1'b0},
      '{16'hAAAA, 1'b0, 16'd0, 1'b0, 1'b0},
      '{16'h0001, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'hFFFE, 1'b0, 16'd0, 1'b0, 1'b0},
      '{16'h00FF, 1'b0, 16'd0, 1'b0, 1'b0},
      '{16'hFF00, 1'b0, 16'd0, 1'b0, 1'b0},
      '{16'h5555, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'hAAAA, 1'b1, 16'd2, 1'b0, 1'b0},
      '{16'h7FFF, 1'b0, 16'd0, 1'b0, 1'b0}
   };

   always #(CLK_PERIOD/2) clock = ~clock;

   code_occurrence_counter_table #(
      .TABLE_ENTRIES (DUT_ENTRIES),
      .CODE_BITS     (DUT_CODE_BITS),
      .COUNT_BITS    (DUT_COUNT_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_event_code    (req_event_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_occurrences   (rsp_occurrences),
      .rsp_new_entry     (rsp_new_entry),
      .rsp_table_flushed (rsp_table_flushed)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   function automatic logic [REQ_CODE_BITS-1:0] random_code();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return REQ_CODE_BITS'($urandom_range(0, 65535));
   endfunction

   // updates the count table for one code and returns the result it gives
   function automatic count_result_type count_code(input logic [REQ_CODE_BITS-1:0] code);
      count_result_type         r;
      logic [DUT_CODE_BITS-1:0] key;
      int                       idx;
      r   = '0;
      key = code[DUT_CODE_BITS-1:0];
      idx = -1;
      for (int i = 0; i < tbl_fill; i++)
         if (idx < 0 && tbl_codes[i] == key) idx = i;
      if (idx >= 0) begin
         if (tbl_counts[idx] != COUNT_MAX) tbl_counts[idx] = tbl_counts[idx] + 1'b1;
         r.occurrences = RSP_COUNT_BITS'(tbl_counts[idx]);
      end else begin
         if (tbl_fill == DUT_ENTRIES) begin
            tbl_fill        = 0;
            r.table_flushed = 1'b1;
         end
         tbl_codes[tbl_fill]  = key;
         tbl_counts[tbl_fill] = DUT_COUNT_BITS'(1);
         tbl_fill++;
         r.occurrences = RSP_COUNT_BITS'(1);
         r.new_entry   = 1'b1;
      end
      return r;
   endfunction

   task automatic send_code(input logic [REQ_CODE_BITS-1:0] code, input logic use_fixed,
                            input count_result_type fixed);
      int               gap;
      count_result_type want;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_event_code <= code;
      do @(posedge clock); while (req_stall);
      want = count_code(code);
      if (use_fixed) want = fixed;
      awaited_counts.push_back(want);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_code_occurrence_counter_table: FAIL");
         $finish;
      end
   end

   // result side: checks each transaction and drives rsp_stall
   initial begin
      count_result_type want;
      int               stall_left;
      int               holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (awaited_counts.size() == 0) begin
               $display("%0t: unexpected result, occurrences %0d new %0b flushed %0b",
                        $time, rsp_occurrences, rsp_new_entry, rsp_table_flushed);
               errors++;
            end else begin
               want = awaited_counts.pop_front();
               if (rsp_occurrences !== want.occurrences) begin
                  $display("%0t: occurrences expected %0d, got %0d",
                           $time, want.occurrences, rsp_occurrences);
                  errors++;
               end
               if (rsp_new_entry !== want.new_entry) begin
                  $display("%0t: new_entry expected %0b, got %0b",
                           $time, want.new_entry, rsp_new_entry);
                  errors++;
               end
               if (rsp_table_flushed !== want.table_flushed) begin
                  $display("%0t: table_flushed expected %0b, got %0b",
                           $time, want.table_flushed, rsp_table_flushed);
                  errors++;
               end
            end
            rsp_seen++;
            if (rsp_new_entry) n_inserts++;
            if (rsp_table_flushed) n_flushes++;
            if (rsp_occurrences == RSP_COUNT_BITS'(COUNT_MAX)) n_saturated++;
         end
         if (rsp_valid && rsp_stall && req_valid && req_stall) n_backpress++;
         if (stall_left > 0) begin
            stall_left--;
         end else if (holds_done < 2 && rsp_seen >= (holds_done == 0 ? 40 : 320)) begin
            // long hold-off so the input side backs up
            stall_left = LONG_HOLD;
            holds_done++;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // request side and run control
   initial begin
      logic [REQ_CODE_BITS-1:0] pool [80];
      int                       total;
      int                       kind;
      int                       len;
      int                       pool_n;
      count_result_type         fixed;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_event_code <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         fixed = '{code_rows[i].occurrences, code_rows[i].new_entry,
                   code_rows[i].table_flushed};
         send_code(code_rows[i].code, code_rows[i].fixed, fixed);
      end

      total = 0;
      while (total < RANDOM_ITEMS) begin
         kind = (total == 0) ? 0 : $urandom_range(0, 9);
         if (kind < 4) begin
            pool_n = (total == 0 || $urandom_range(0, 1)) ? 1 : $urandom_range(2, 3);
            len    = $urandom_range(70, 140);
         end else if (kind < 8) begin
            pool_n = $urandom_range(40, 80);
            len    = $urandom_range(60, 140);
         end else begin
            pool_n = 0;
            len    = $urandom_range(10, 30);
         end
         for (int i = 0; i < pool_n; i++) pool[i] = random_code();
         for (int j = 0; j < len && total < RANDOM_ITEMS; j++) begin
            quiet = (total >= 250 && total < 330);
            send_code(pool_n != 0 ? pool[$urandom_range(0, pool_n - 1)] : random_code(),
                      1'b0, '0);
            total++;
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (awaited_counts.size() != 0) @(posedge clock);
      repeat (DUT_ENTRIES + 8) @(posedge clock);

      $display("%0d results checked: %0d insertions, %0d table flushes, %0d saturated counts",
               rsp_seen, n_inserts, n_flushes, n_saturated);
      $display("%0d cycles with both channels held by back-pressure", n_backpress);
      if (errors == 0 && awaited_counts.size() == 0)
         $display("tb_code_occurrence_counter_table: PASS");
      else
         $display("tb_code_occurrence_counter_table: FAIL");
      $finish;
   end

endmodule
